// File: rtl/first_fit_heap_allocator_assert.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared widths, codes and types for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int ADDR_W = 14;  // payload offset width
  localparam int LEN_W  = 15;  // extent start/length and block size width
  localparam int NEED_W = 16;  // rounded request plus header
  localparam int HSZ_W  = 15;  // heap_size register width

  localparam int HEAP_BYTES_DEF   = 16384;
  localparam int MAX_EXTENTS_DEF  = 32;
  localparam int HEADER_BYTES_DEF = 8;

  localparam logic [HSZ_W-1:0]  HEAP_SIZE_RST = 15'd16384;
  localparam logic [NEED_W-1:0] ADDR_MAX      = 16'h3FFF;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REG_HEAP_SIZE = 1'b0;  // paddr[2] of heap_size

  typedef struct packed {
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] length;
  } extent_t;

endpackage

// File: rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with an address-sorted, coalescing free extent table.
// ----------------------------------------------------------------------------
// Allocate walks the table from entry zero up to the first fit; when the whole
//   extent is taken, the entries after it are moved down to close the hole.
// Release looks up the block size and walks to its slot p, then moves the
//   entries above it on an insert or a two-sided merge.
// One transfer in at a time; the next is accepted once the sequencer is back
//   in idle after the result loads. The table is walked one entry a cycle. Reset
//   (and any heap_size write) rewrites entry zero; block sizes are not cleared.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int MAX_EXTENTS  = MAX_EXTENTS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [ADDR_W-1:0] request_bytes,
  input  logic [ADDR_W-1:0] release_addr,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] block_addr,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int STORE_DEPTH = HEAP_BYTES / 4;
  localparam int SW = $clog2(STORE_DEPTH);
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [31:0] STORE_DEPTH_W = 32'(STORE_DEPTH);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

  // sequencer states
  localparam logic [3:0] S_INIT  = 4'd0;  // write entry zero
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;  // first-fit walk
  localparam logic [3:0] S_RLOOK = 4'd3;  // block size comes back
  localparam logic [3:0] S_RSCAN = 4'd4;  // find insert slot
  localparam logic [3:0] S_RDEC  = 4'd5;  // merge decision
  localparam logic [3:0] S_SHDN  = 4'd6;  // close a hole
  localparam logic [3:0] S_SHUP  = 4'd7;  // open a hole
  localparam logic [3:0] S_SINS  = 4'd8;  // write new extent
  localparam logic [3:0] S_OUT   = 4'd9;  // hand result to output reg

  logic [3:0]        state;
  logic [HSZ_W-1:0]  heap_size;
  logic [LEN_W-1:0]  heap_eff;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     dst;
  logic [CW-1:0]     pos;
  logic              pipe;
  logic              rd_on;
  logic [NEED_W-1:0] need_r;
  logic [ADDR_W-1:0] h_r;
  logic [LEN_W-1:0]  size_r;
  extent_t           prev;
  extent_t           nxt;
  logic              pvld;
  logic              nvld;
  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_addr;

  // RAM hookups
  logic              ext_we;
  logic [CW-1:0]     ext_wa;
  extent_t           ext_wd;
  extent_t           ext_rd;
  logic              sto_we;
  logic [SW-1:0]     sto_wa;
  logic [LEN_W-1:0]  sto_wd;
  logic [LEN_W-1:0]  sto_rd;
  logic [SW-1:0]     sto_ra;

  ffha_ram #(.WIDTH(2*LEN_W), .DEPTH(MAX_EXTENTS)) u_ext (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_wa[IW-1:0]),
    .wdata (ext_wd),
    .raddr (ptr[IW-1:0]),
    .rdata (ext_rd)
  );

  ffha_ram #(.WIDTH(LEN_W), .DEPTH(STORE_DEPTH)) u_size (
    .clk   (clk),
    .we    (sto_we),
    .waddr (sto_wa),
    .wdata (sto_wd),
    .raddr (sto_ra),
    .rdata (sto_rd)
  );

  // Effective heap: saturate to the parameter, round down to a word.
  logic [LEN_W-1:0] heap_sat;
  always_comb begin
    heap_sat = (32'(heap_size) > 32'(HEAP_BYTES)) ? LEN_W'(HEAP_BYTES) : heap_size;
    heap_eff = {heap_sat[LEN_W-1:2], 2'b00};
  end

  // Register port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEAP_SIZE);
  assign prdata = (paddr[2] == REG_HEAP_SIZE) ? 32'(heap_size) : 32'd0;

  assign in_stall = (state != S_IDLE);

  // Input decode
  logic              accept;
  logic [NEED_W-1:0] need_in;
  logic [ADDR_W-1:0] h_in;
  logic              rel_ok;
  assign accept  = in_valid && !in_stall;
  assign need_in = ((NEED_W'(request_bytes) + NEED_W'(3)) & ~NEED_W'(3))
                   + NEED_W'(HEADER_BYTES);
  assign h_in    = release_addr - ADDR_W'(HEADER_BYTES);
  assign rel_ok  = (32'(release_addr) >= 32'(HEADER_BYTES)) && (h_in[1:0] == 2'b00)
                   && (32'(h_in[ADDR_W-1:2]) < STORE_DEPTH_W);
  assign sto_ra  = SW'(h_in[ADDR_W-1:2]);

  // First-fit test on the entry coming out of the table
  logic              fits;
  logic [NEED_W-1:0] rem;
  logic              take_all;
  assign rem      = NEED_W'(ext_rd.length) - need_r;
  assign fits     = (NEED_W'(ext_rd.length) >= need_r)
                    && (NEED_W'(ext_rd.start) + NEED_W'(HEADER_BYTES) <= ADDR_MAX)
                    && (32'(ext_rd.start[LEN_W-1:2]) < STORE_DEPTH_W);
  assign take_all = (rem <= NEED_W'(HEADER_BYTES));

  // Release neighbor tests
  logic [NEED_W-1:0] blk_end;
  logic [NEED_W-1:0] prev_end;
  logic              left;
  logic              right;
  logic              overlap;
  assign blk_end  = NEED_W'(h_r) + NEED_W'(size_r);
  assign prev_end = NEED_W'(prev.start) + NEED_W'(prev.length);
  assign overlap  = (pvld && (prev_end > NEED_W'(h_r)))
                    || (nvld && (NEED_W'(nxt.start) < blk_end));
  assign left     = pvld && (prev_end == NEED_W'(h_r));
  assign right    = nvld && (NEED_W'(nxt.start) == blk_end);

  // Table and size-store writes
  always_comb begin
    ext_we = 1'b0;
    ext_wa = '0;
    ext_wd = ext_rd;
    sto_we = 1'b0;
    sto_wa = SW'(ext_rd.start[LEN_W-1:2]);
    sto_wd = ext_rd.length;
    case (state)
      S_INIT: begin
        ext_we = 1'b1;
        ext_wd = '{start: '0, length: heap_eff};
      end
      S_ASCAN: begin
        if (pipe && fits) begin
          sto_we = 1'b1;
          if (!take_all) begin
            sto_wd = LEN_W'(need_r);
            ext_we = 1'b1;
            ext_wa = ptr - CW'(1);
            ext_wd = '{start: LEN_W'(NEED_W'(ext_rd.start) + need_r),
                       length: LEN_W'(rem)};
          end
        end
      end
      S_RDEC: begin
        if (!overlap) begin
          if (left) begin
            ext_we = 1'b1;
            ext_wa = pos - CW'(1);
            ext_wd = '{start: prev.start,
                       length: right ? prev.length + size_r + nxt.length
                                     : prev.length + size_r};
          end else if (right) begin
            ext_we = 1'b1;
            ext_wa = pos;
            ext_wd = '{start: LEN_W'(h_r), length: nxt.length + size_r};
          end else if (count == pos && count < MAX_CNT) begin
            ext_we = 1'b1;
            ext_wa = pos;
            ext_wd = '{start: LEN_W'(h_r), length: size_r};
          end
        end
      end
      S_SHDN, S_SHUP: begin
        ext_we = pipe;
        ext_wa = dst;
        ext_wd = ext_rd;
      end
      S_SINS: begin
        ext_we = 1'b1;
        ext_wa = pos;
        ext_wd = '{start: LEN_W'(h_r), length: size_r};
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      heap_size <= HEAP_SIZE_RST;
      count     <= '0;
      out_valid <= 1'b0;
      pipe      <= 1'b0;
      rd_on     <= 1'b0;
    end else begin
      // S_OUT loads the next result itself
      if (out_valid && !out_stall && (state != S_OUT || cfg_wr)) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        // a heap_size write rebuilds the table
        heap_size <= pwdata[HSZ_W-1:0];
        state     <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            count <= (heap_eff != '0) ? CW'(1) : '0;
            state <= S_IDLE;
          end
          S_IDLE: begin
            if (accept) begin
              ptr        <= '0;
              pipe       <= 1'b0;
              pvld       <= 1'b0;
              nvld       <= 1'b0;
              need_r     <= need_in;
              h_r        <= h_in;
              res_status <= ST_DONE;
              res_addr   <= '0;
              if (operation == OP_ALLOC) begin
                state <= S_ASCAN;
              end else if (rel_ok) begin
                state <= S_RLOOK;
              end else begin
                state <= S_OUT;  // malformed release is ignored
              end
            end
          end
          S_ASCAN: begin
            if (pipe && fits) begin
              res_addr <= ADDR_W'(ext_rd.start + LEN_W'(HEADER_BYTES));
              if (take_all) begin
                dst   <= ptr - CW'(1);
                pipe  <= 1'b0;
                state <= S_SHDN;
              end else begin
                state <= S_OUT;
              end
            end else if (ptr == count) begin
              res_status <= ST_NOFIT;
              state      <= S_OUT;
            end else begin
              ptr  <= ptr + CW'(1);
              pipe <= 1'b1;
            end
          end
          S_RLOOK: begin
            size_r <= sto_rd;
            if (sto_rd == '0 || NEED_W'(h_r) + NEED_W'(sto_rd) > NEED_W'(heap_eff)) begin
              state <= S_OUT;
            end else begin
              state <= S_RSCAN;
            end
          end
          S_RSCAN: begin
            if (pipe && (NEED_W'(ext_rd.start) > NEED_W'(h_r))) begin
              pos   <= ptr - CW'(1);
              nxt   <= ext_rd;
              nvld  <= 1'b1;
              state <= S_RDEC;
            end else begin
              if (pipe) begin
                prev <= ext_rd;
                pvld <= 1'b1;
              end
              if (ptr == count) begin
                pos   <= count;
                state <= S_RDEC;
              end else begin
                ptr  <= ptr + CW'(1);
                pipe <= 1'b1;
              end
            end
          end
          S_RDEC: begin
            pipe <= 1'b0;
            if (overlap) begin
              state <= S_OUT;
            end else if (left && right) begin
              dst   <= pos;
              ptr   <= pos + CW'(1);
              state <= S_SHDN;
            end else if (left || right) begin
              state <= S_OUT;
            end else if (count >= MAX_CNT) begin
              res_status <= ST_FULL;
              state      <= S_OUT;
            end else if (count == pos) begin
              count <= count + CW'(1);
              state <= S_OUT;
            end else begin
              ptr   <= count - CW'(1);
              dst   <= count;
              rd_on <= 1'b1;
              state <= S_SHUP;
            end
          end
          S_SHDN: begin
            if (pipe) begin
              dst <= dst + CW'(1);
            end
            if (ptr == count) begin
              count <= count - CW'(1);
              pipe  <= 1'b0;
              state <= S_OUT;
            end else begin
              ptr  <= ptr + CW'(1);
              pipe <= 1'b1;
            end
          end
          S_SHUP: begin
            // reads stop at pos, so the last write sees rd_on already low
            pipe <= rd_on;
            if (rd_on) begin
              if (ptr == pos) begin
                rd_on <= 1'b0;
              end else begin
                ptr <= ptr - CW'(1);
              end
            end
            if (pipe) begin
              dst <= dst - CW'(1);
              if (dst == pos + CW'(1)) begin
                state <= S_SINS;
              end
            end
          end
          S_SINS: begin
            count <= count + CW'(1);
            state <= S_OUT;
          end
          S_OUT: begin
            if (!out_valid || !out_stall) begin
              out_valid  <= 1'b1;
              status     <= res_status;
              block_addr <= res_addr;
              state      <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker
  import ffha_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic [ADDR_W-1:0] block_addr
);

  `FFHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(block_addr), "stalled result changed")
  `FFHA_ASSERT_NOW(a_status_code, out_valid, status == ST_DONE || status == ST_NOFIT || status == ST_FULL, "bad status code")
  `FFHA_ASSERT_NOW(a_addr_zero, out_valid && status != ST_DONE, block_addr == '0, "address on failed request")
  `FFHA_ASSERT_NEXT(a_busy_after, in_valid && !in_stall, in_stall, "accepted a second item back to back")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .block_addr (block_addr)
);
